// File: design/nas_pkg.sv
// ----------------------------------------------------------------------------
// nas_pkg
// Shared constants for the note arpeggiator sequencer: field widths, item
// mode codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
package nas_pkg;

  // Default table size
  localparam int NAS_MAX_NOTES = 16;

  // Field widths
  localparam int MODE_W      = 3;
  localparam int NOTE_IDX_W  = 4;
  localparam int NOTE_W      = 8;
  localparam int INTERVAL_W  = 16;
  localparam int COUNT_W     = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int S_TDATA_W   = 16;
  localparam int M_TDATA_W   = 16;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_TICK    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_START   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_STOP    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FORWARD = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REVERSE = 3'd4;
  localparam logic [MODE_W-1:0] MODE_JUMP    = 3'd5;
  localparam logic [MODE_W-1:0] MODE_ADVANCE = 3'd6;
  localparam logic [MODE_W-1:0] MODE_LOAD    = 3'd7;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOTE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_AT_END = 2'd2;

  // Register reset values
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST   = 16'd500;
  localparam logic [COUNT_W-1:0]    NOTE_COUNT_RST = 5'd1;

endpackage

// File: design/note_arpeggiator_sequencer_top.sv
// ----------------------------------------------------------------------------
// note_arpeggiator_sequencer_top
// Step sequencer that plays a loaded note table at a beat interval counted
// in millisecond tick items, with start/stop, direction, jump, manual
// advance and table load commands.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tuser: mode; tdata: note_index, note_value
//  m_*      out  m_tvalid/m_tready  tuser: note_valid; tdata: note, running
//  cfg_*    in   cfg_we             cfg_index, cfg_data (no read-back)
//
//  One item per cycle while m_tready is high; an item passes the input stage
//  and then the result register. The state update, table read and wrap step all sit between
//  those two registers.
//  Reset (rst, synchronous) clears the note table, position, direction,
//  beat counter and run flag, and loads register defaults.
//  While m_tready is low the result holds and one more item waits in the
//  input stage; s_tready drops only when both are full.
// ----------------------------------------------------------------------------
module note_arpeggiator_sequencer_top
  import nas_pkg::*;
#(
  parameter int MAX_NOTES = NAS_MAX_NOTES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // [3:0] note_index, [11:4] note_value, rest zero
  input  logic [MODE_W-1:0]     s_tuser,   // [2:0] mode
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,   // [7:0] note, [8] running, rest zero
  output logic                  m_tuser,   // [0] note_valid
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Entries that a load can reach, and the largest usable count
  localparam int IDX_SPAN  = 2 ** NOTE_IDX_W;
  localparam int TBL_DEPTH = (MAX_NOTES < IDX_SPAN) ? MAX_NOTES : IDX_SPAN;
  localparam int CNT_MAX   = (2 ** COUNT_W) - 1;
  localparam int USED_MAX  = (MAX_NOTES < CNT_MAX) ? MAX_NOTES : CNT_MAX;
  localparam int POS_W     = $clog2(USED_MAX);
  localparam int TIDX_W    = $clog2(TBL_DEPTH);
  localparam logic [COUNT_W-1:0] USED_MAX_V = COUNT_W'(USED_MAX);

  // Configuration registers
  logic [INTERVAL_W-1:0] interval_ms;
  logic [COUNT_W-1:0]    note_count;
  logic                  stop_at_end;

  // Sequencer state
  logic [NOTE_W-1:0]     note_table [TBL_DEPTH];
  logic [POS_W-1:0]      position;
  logic                  going_back;
  logic                  active_flag;
  logic [INTERVAL_W-1:0] wait_count;

  // Input stage
  logic                  s1_valid;
  logic [MODE_W-1:0]     s1_mode;
  logic [NOTE_IDX_W-1:0] s1_idx;
  logic [NOTE_W-1:0]     s1_val;
  logic                  s1_fire;

  // Result register
  logic                  res_valid;
  logic [NOTE_W-1:0]     res_note;
  logic                  res_running;

  // Next-state values
  logic [POS_W-1:0]      position_next;
  logic                  going_back_next;
  logic                  active_next;
  logic [INTERVAL_W-1:0] wait_count_next;
  logic                  do_emit;
  logic [POS_W-1:0]      emit_pos;
  logic [POS_W-1:0]      emit_step;
  logic [NOTE_W-1:0]     emit_note;
  logic [NOTE_W-1:0]     note_out;
  logic                  do_load;

  // Clamped count and derived values
  logic [COUNT_W-1:0]    used5;
  logic [POS_W-1:0]      last_pos;
  logic [COUNT_W-1:0]    idx5;
  logic [POS_W-1:0]      idx_pos;
  logic                  idx_in_range;

  // One wrap step inside the used part of the table
  function automatic logic [POS_W-1:0] step_pos(input logic [POS_W-1:0] p,
                                                input logic [POS_W-1:0] last,
                                                input logic             back);
    logic [POS_W-1:0] r;
    if (back) begin
      r = (p == '0) ? last : p - POS_W'(1);
    end else begin
      r = (p == last) ? '0 : p + POS_W'(1);
    end
    return r;
  endfunction

  // Clamp the note count to 1..USED_MAX
  always_comb begin
    if (note_count == '0) begin
      used5 = COUNT_W'(1);
    end else if (note_count > USED_MAX_V) begin
      used5 = USED_MAX_V;
    end else begin
      used5 = note_count;
    end
  end

  assign last_pos     = POS_W'(used5 - COUNT_W'(1));
  assign idx5         = {1'b0, s1_idx};
  assign idx_pos      = idx5[POS_W-1:0];
  assign idx_in_range = idx5 < used5;

  // Handshake
  assign s1_fire  = s1_valid && (!res_valid || m_tready);
  assign s_tready = !s1_valid || s1_fire;

  // Decode the item and work out the next state
  always_comb begin
    position_next   = position;
    going_back_next = going_back;
    active_next     = active_flag;
    wait_count_next = wait_count;
    do_emit         = 1'b0;
    do_load         = 1'b0;
    emit_pos        = position;
    unique case (s1_mode)
      MODE_TICK: begin
        if (active_flag) begin
          if (wait_count == '0) begin
            wait_count_next = (interval_ms == '0) ? '0 : interval_ms - INTERVAL_W'(1);
            do_emit         = 1'b1;
          end else begin
            wait_count_next = wait_count - INTERVAL_W'(1);
          end
        end
      end
      MODE_START: begin
        active_next     = 1'b1;
        wait_count_next = '0;
      end
      MODE_STOP: begin
        active_next = 1'b0;
      end
      MODE_FORWARD: begin
        if (going_back) begin
          going_back_next = 1'b0;
          position_next   = step_pos(step_pos(position, last_pos, 1'b0), last_pos, 1'b0);
        end
      end
      MODE_REVERSE: begin
        if (!going_back) begin
          going_back_next = 1'b1;
          position_next   = step_pos(step_pos(position, last_pos, 1'b1), last_pos, 1'b1);
        end
      end
      MODE_JUMP: begin
        if (idx_in_range) begin
          emit_pos = idx_pos;
          do_emit  = 1'b1;
        end
      end
      MODE_ADVANCE: begin
        do_emit = 1'b1;
      end
      MODE_LOAD: begin
        do_load = 1'b1;
      end
    endcase

    // Emit: read the note, step the position, stop on wrap if asked
    emit_step = step_pos(emit_pos, last_pos, going_back);
    if (do_emit) begin
      position_next = emit_step;
      if (stop_at_end && emit_step == '0) begin
        active_next = 1'b0;
      end
    end
  end

  // Table read; entries beyond the loadable range stay zero
  always_comb begin
    if (32'(emit_pos) < TBL_DEPTH) begin
      emit_note = note_table[emit_pos[TIDX_W-1:0]];
    end else begin
      emit_note = '0;
    end
  end

  assign note_out = do_emit ? emit_note : '0;

  // Input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      s1_mode <= s_tuser;
      s1_idx  <= s_tdata[NOTE_IDX_W-1:0];
      s1_val  <= s_tdata[NOTE_IDX_W +: NOTE_W];
    end
  end

  // Sequencer state and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= '0;
      going_back  <= 1'b0;
      active_flag <= 1'b0;
      wait_count  <= '0;
      interval_ms <= INTERVAL_RST;
      note_count  <= NOTE_COUNT_RST;
      stop_at_end <= 1'b0;
      for (int i = 0; i < TBL_DEPTH; i++) begin
        note_table[i] <= '0;
      end
    end else begin
      // A note count write restarts the position
      if (cfg_we && cfg_index == REG_NOTE_COUNT) begin
        position <= '0;
      end else if (s1_fire) begin
        position <= position_next;
      end
      if (s1_fire) begin
        going_back  <= going_back_next;
        active_flag <= active_next;
        wait_count  <= wait_count_next;
        if (do_load && 32'(s1_idx) < TBL_DEPTH) begin
          note_table[s1_idx[TIDX_W-1:0]] <= s1_val;
        end
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_INTERVAL: begin
            interval_ms <= cfg_data;
          end
          REG_NOTE_COUNT: begin
            note_count <= cfg_data[COUNT_W-1:0];
          end
          REG_STOP_AT_END: begin
            stop_at_end <= cfg_data[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Result register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_fire) begin
      res_valid <= 1'b1;
    end else if (m_tready) begin
      res_valid <= 1'b0;
    end
    if (s1_fire) begin
      res_note    <= note_out;
      res_running <= active_next;
      m_tuser     <= do_emit;
    end
  end

  assign m_tvalid = res_valid;
  assign m_tdata  = {{(M_TDATA_W - NOTE_W - 1){1'b0}}, res_running, res_note};

endmodule

// File: design/nas_checker.sv
// ----------------------------------------------------------------------------
// nas_checker
// Port-level checks for the note arpeggiator sequencer, bound to the top.
// ----------------------------------------------------------------------------
module nas_checker
  import nas_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic                 m_tuser
);

  // No result comes out of reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // A result without a note carries a zero note value
  a_note_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[NOTE_W-1:0] == '0)
    else $error("note value set without note_valid");

  // Input side is never blocked while the result register is empty
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty result register");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // An item accepted while the result register is empty yields a valid result after the input stage
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid |=> ##1 m_tvalid)
    else $error("accepted item did not produce a result");

endmodule

bind note_arpeggiator_sequencer_top nas_checker u_nas_checker (.*);
